[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL; empty for synthesis.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge outside of reset.
`define TSD_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define TSD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`else

`define TSD_ASSERT_RST(lbl, clk, rstn, prop, msg)
`define TSD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

[rtl/tsd_pkg.sv]
// ---------------------------------------------------------------------------
// tsd_pkg
// Types and constants of the transport stream packet size and sync detector.
// ---------------------------------------------------------------------------
package tsd_pkg;

  // Packets tested per candidate offset
  localparam int TRY_PACKETS = 5;

  localparam int SIZE_SHORT_I = 188;
  localparam int SIZE_LONG_I  = 204;

  // Byte distance from a candidate to its last test byte
  localparam int SPAN_LAG = SIZE_LONG_I * (TRY_PACKETS - 1);

  localparam logic [7:0] SIZE_SHORT = 8'd188;
  localparam logic [7:0] SIZE_LONG  = 8'd204;

  // "OTV :-)"
  localparam logic [55:0] SIGNATURE = 56'h4F5456203A2D29;

  localparam logic [31:0] HDR_LAST_POS = 32'd6;

  // Configuration register indexes
  localparam logic [1:0] REG_SYNC_VALUE  = 2'd0;
  localparam logic [1:0] REG_ZERO_RUN    = 2'd1;
  localparam logic [1:0] REG_SEARCH_SPAN = 2'd2;

  localparam logic [7:0]  SYNC_VALUE_RST  = 8'd71;
  localparam logic [7:0]  ZERO_RUN_RST    = 8'd10;
  localparam logic [10:0] SEARCH_SPAN_RST = 11'd204;

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_ZEROS  = 4'b0010,
    PH_SEARCH = 4'b0100,
    PH_DONE   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [7:0]  sync_value;
    logic [7:0]  zero_run;
    logic [10:0] search_span;
  } cfg_t;

  // Sync tests for the candidate under judgment
  typedef struct packed {
    logic head;
    logic pass_short;
    logic pass_long;
  } tap_t;

  typedef struct packed {
    logic        header_seen;
    logic        search_done;
    logic        locked;
    logic [7:0]  packet_size;
    logic [31:0] stream_offset;
  } res_t;

endpackage

[rtl/tsd_hist.sv]
// ---------------------------------------------------------------------------
// tsd_hist
// Shift line of sync match bits with fixed taps at packet spacings.
// ---------------------------------------------------------------------------
module tsd_hist import tsd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic adv,
  input  logic restart,
  input  logic match,
  output tap_t taps
);

  // Bit k holds the byte k+1 positions before the one now in the step
  logic [SPAN_LAG-1:0] hist_r;
  logic [SPAN_LAG-1:0] hist_nxt;

  // Bit k is the byte k positions back; bit 0 is the byte in the step
  logic [SPAN_LAG:0]   hist_line;

  logic [TRY_PACKETS-2:0] tap_short;
  logic [TRY_PACKETS-2:0] tap_long;

  always_comb begin
    if (restart) begin
      hist_nxt = {{(SPAN_LAG-1){1'b0}}, match};
    end else begin
      hist_nxt = {hist_r[SPAN_LAG-2:0], match};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r <= '0;
    end else if (adv) begin
      hist_r <= hist_nxt;
    end
  end

  assign hist_line = {hist_r, match};

  for (genvar t = 1; t < TRY_PACKETS; t++) begin : g_tap
    assign tap_short[t-1] = hist_line[SPAN_LAG - SIZE_SHORT_I*t];
    assign tap_long[t-1]  = hist_line[SPAN_LAG - SIZE_LONG_I*t];
  end

  // A restart empties the line, so every tap reads zero for that beat
  assign taps.head       = !restart && hist_line[SPAN_LAG];
  assign taps.pass_short = !restart && (&tap_short);
  assign taps.pass_long  = !restart && (&tap_long);

endmodule

[rtl/tsd_ctrl.sv]
// ---------------------------------------------------------------------------
// tsd_ctrl
// Header check, zero run count and candidate search; holds the result.
// ---------------------------------------------------------------------------
module tsd_ctrl import tsd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic       restart,
  input  logic [7:0] data_byte,
  input  cfg_t       cfg,
  input  tap_t       taps,
  output res_t       res
);

  logic [31:0] pos_r,  pos_nxt;
  logic [55:0] hdr_r,  hdr_nxt;
  phase_t      phase_r, phase_nxt;
  logic [31:0] base_r, base_nxt;
  logic [7:0]  zcnt_r, zcnt_nxt;
  logic [31:0] cand_r, cand_nxt;
  logic        lock_r, lock_nxt;
  logic [7:0]  size_r, size_nxt;
  logic [31:0] loff_r, loff_nxt;
  logic        seen_r, seen_nxt;

  logic [31:0] pos_c, base_c, cand_c;
  logic [55:0] hdr_c;
  phase_t      phase_c;
  logic [7:0]  zcnt_c;
  logic        judge;
  logic [7:0]  size_found;

  always_comb begin
    // restart clears the state before this beat is taken in
    pos_c   = restart ? '0 : pos_r;
    hdr_c   = restart ? '0 : hdr_r;
    phase_c = restart ? PH_HEADER : phase_r;
    base_c  = restart ? '0 : base_r;
    zcnt_c  = restart ? '0 : zcnt_r;
    cand_c  = restart ? '0 : cand_r;
    lock_nxt = restart ? 1'b0 : lock_r;
    size_nxt = restart ? '0 : size_r;
    loff_nxt = restart ? '0 : loff_r;

    if (data_byte == 8'd0) begin
      zcnt_nxt = (zcnt_c == 8'hFF) ? zcnt_c : zcnt_c + 8'd1;
    end else begin
      zcnt_nxt = '0;
    end

    hdr_nxt   = hdr_c;
    phase_nxt = phase_c;
    base_nxt  = base_c;
    cand_nxt  = cand_c;

    case (phase_c)
      PH_HEADER: begin
        hdr_nxt = {hdr_c[47:0], data_byte};
        if (pos_c == HDR_LAST_POS) begin
          if (hdr_nxt == SIGNATURE && cfg.zero_run != 8'd0) begin
            phase_nxt = PH_ZEROS;
          end else begin
            base_nxt  = '0;
            cand_nxt  = '0;
            phase_nxt = PH_SEARCH;
          end
        end
      end
      PH_ZEROS: begin
        if (zcnt_nxt >= cfg.zero_run) begin
          base_nxt  = pos_c;
          cand_nxt  = pos_c;
          phase_nxt = PH_SEARCH;
        end
      end
      PH_SEARCH, PH_DONE: begin
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase

    if (taps.head && taps.pass_short) begin
      size_found = SIZE_SHORT;
    end else if (taps.head && taps.pass_long) begin
      size_found = SIZE_LONG;
    end else begin
      size_found = '0;
    end

    // candidate is judged once its last test byte is in
    judge = (phase_nxt == PH_SEARCH) && ((pos_c - cand_nxt) == 32'(SPAN_LAG));
    if (judge) begin
      if ((cand_nxt - base_nxt) >= {21'd0, cfg.search_span}) begin
        phase_nxt = PH_DONE;
      end else if (size_found != 8'd0) begin
        lock_nxt  = 1'b1;
        size_nxt  = size_found;
        loff_nxt  = cand_nxt;
        phase_nxt = PH_DONE;
      end else begin
        cand_nxt = cand_nxt + 32'd1;
      end
    end

    pos_nxt  = pos_c + 32'd1;
    seen_nxt = (pos_c >= HDR_LAST_POS || phase_nxt != PH_HEADER) && hdr_nxt == SIGNATURE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      hdr_r   <= '0;
      phase_r <= PH_HEADER;
      base_r  <= '0;
      zcnt_r  <= '0;
      cand_r  <= '0;
      lock_r  <= 1'b0;
      size_r  <= '0;
      loff_r  <= '0;
      seen_r  <= 1'b0;
    end else if (adv) begin
      pos_r   <= pos_nxt;
      hdr_r   <= hdr_nxt;
      phase_r <= phase_nxt;
      base_r  <= base_nxt;
      zcnt_r  <= zcnt_nxt;
      cand_r  <= cand_nxt;
      lock_r  <= lock_nxt;
      size_r  <= size_nxt;
      loff_r  <= loff_nxt;
      seen_r  <= seen_nxt;
    end
  end

  assign res.header_seen   = seen_r;
  assign res.search_done   = (phase_r == PH_DONE);
  assign res.locked        = lock_r;
  assign res.packet_size   = size_r;
  assign res.stream_offset = loff_r;

endmodule

[rtl/ts_packet_size_sync_detector_unit.sv]
// ---------------------------------------------------------------------------
// ts_packet_size_sync_detector_unit
// Finds packet size (188 or 204) and first sync offset in a byte stream.
// ---------------------------------------------------------------------------
//  channel  direction  ports                                    beat
//  in       input      in_valid/in_stall, in_data_byte, in_restart   one stream byte
//  out      output     out_valid/out_stall, out_header_seen ...      status after a byte
//  cfg      input      cfg_wr_en, cfg_index, cfg_wdata               register write
//
//  One beat per cycle in and out unless stalled; a byte's status goes out
//  once it has passed the input register, then the state and result register.
//  The sync history is a fixed 816-bit shift line, read at constant taps.
//  rst_n is synchronous and clears the state and the registers to defaults.
//  out_stall holds both stages; in_stall rises only when the input register
//  is full and cannot move on.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ts_packet_size_sync_detector_unit import tsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_data_byte,
  input  logic        in_restart,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_header_seen,
  output logic        out_search_done,
  output logic        out_locked,
  output logic [7:0]  out_packet_size,
  output logic [31:0] out_stream_offset,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [10:0] cfg_wdata
);

  cfg_t       cfg_r;
  logic       s1_valid_r;
  logic [7:0] s1_data_r;
  logic       s1_restart_r;
  logic       out_valid_r;
  logic       o_rdy;
  logic       s1_rdy;
  logic       step;
  logic       match;
  tap_t       taps;
  res_t       res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.sync_value  <= SYNC_VALUE_RST;
      cfg_r.zero_run    <= ZERO_RUN_RST;
      cfg_r.search_span <= SEARCH_SPAN_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_SYNC_VALUE:  cfg_r.sync_value  <= cfg_wdata[7:0];
        REG_ZERO_RUN:    cfg_r.zero_run    <= cfg_wdata[7:0];
        REG_SEARCH_SPAN: cfg_r.search_span <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign o_rdy    = !out_valid_r || !out_stall;
  assign s1_rdy   = !s1_valid_r || o_rdy;
  assign in_stall = !s1_rdy;
  assign step     = s1_valid_r && o_rdy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_valid_r <= in_valid;
      end
      if (o_rdy) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // hold the byte in the input register until the step takes it
  always_ff @(posedge clk) begin
    if (s1_rdy && in_valid) begin
      s1_data_r    <= in_data_byte;
      s1_restart_r <= in_restart;
    end
  end

  assign match = (s1_data_r == cfg_r.sync_value);

  tsd_hist u_hist (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (step),
    .restart (s1_restart_r),
    .match   (match),
    .taps    (taps)
  );

  tsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (step),
    .restart   (s1_restart_r),
    .data_byte (s1_data_r),
    .cfg       (cfg_r),
    .taps      (taps),
    .res       (res)
  );

  assign out_valid         = out_valid_r;
  assign out_header_seen   = res.header_seen;
  assign out_search_done   = res.search_done;
  assign out_locked        = res.locked;
  assign out_packet_size   = res.packet_size;
  assign out_stream_offset = res.stream_offset;

  `TSD_ASSERT_RST(a_lock_done, clk, rst_n, res.locked |-> res.search_done, "lock without done")
  `TSD_ASSERT_RST(a_lock_size, clk, rst_n, res.locked |-> (res.packet_size == SIZE_SHORT || res.packet_size == SIZE_LONG), "bad packet size")
  `TSD_ASSERT_RST(a_unlock_zero, clk, rst_n, !res.locked |-> (res.packet_size == 8'd0 && res.stream_offset == 32'd0), "stale lock fields")
  `TSD_ASSERT_RST(a_step_out, clk, rst_n, step |=> out_valid_r, "stepped beat not presented")
  `TSD_ASSERT_RST(a_hold_s1, clk, rst_n, (s1_valid_r && !o_rdy) |=> s1_valid_r, "held beat lost")

endmodule

[dv/tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Byte stream checker for the packet size and sync detector: a tracker of
// the search state predicts the status of every byte, and a monitor compares
// each status beat with it field by field.
// ---------------------------------------------------------------------------
module tb import tsd_pkg::*;;

  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  typedef struct {
    logic [7:0] data;
    logic       restart;
    bit         drain;  // hold this beat until every status is back
  } stream_beat_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  in_data_byte = 8'd0;
  logic        in_restart = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_header_seen;
  logic        out_search_done;
  logic        out_locked;
  logic [7:0]  out_packet_size;
  logic [31:0] out_stream_offset;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = REG_SYNC_VALUE;
  logic [10:0] cfg_wdata = 11'd0;

  ts_packet_size_sync_detector_unit dut (.*);

  always #6 clk = ~clk;

  stream_beat_t pending_beats[$];
  res_t         status_q[$];
  idle_mode_t   idle_mode = IDLE_NONE;
  int           bytes_taken = 0;
  int           statuses_seen = 0;
  int           err_count = 0;
  int           quiet_cycles = 0;
  int           locks_short = 0;
  int           locks_long = 0;
  int           searches_failed = 0;

  // Search tracker and its copy of the registers
  cfg_t           trk_cfg = '{SYNC_VALUE_RST, ZERO_RUN_RST, SEARCH_SPAN_RST};
  logic [SPAN_LAG:0] sync_hist = '0;
  logic [31:0]    byte_pos = '0;
  logic [55:0]    hdr_bytes = '0;
  phase_t         phase = PH_HEADER;
  logic [31:0]    base_off = '0;
  logic [31:0]    cand_off = '0;
  logic [7:0]     zero_cnt = '0;
  logic           lock_vld = 1'b0;
  logic [7:0]     lock_sz = '0;
  logic [31:0]    lock_off = '0;

  function automatic void clear_tracker();
    sync_hist = '0;
    byte_pos  = '0;
    hdr_bytes = '0;
    phase     = PH_HEADER;
    base_off  = '0;
    cand_off  = '0;
    zero_cnt  = '0;
    lock_vld  = 1'b0;
    lock_sz   = '0;
    lock_off  = '0;
  endfunction

  // Oldest tracked byte is the candidate; look for syncs at sp, 2*sp, ... after it
  function automatic bit spaced_syncs(int sp);
    bit ok;
    ok = 1'b1;
    for (int t = 1; t < TRY_PACKETS; t++) begin
      if (!sync_hist[SPAN_LAG - sp * t]) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic res_t track_byte(logic [7:0] b, logic rs);
    logic [31:0] pos;
    logic [7:0]  sz;
    res_t        r;
    if (rs) clear_tracker();
    pos = byte_pos;
    sync_hist = {sync_hist[SPAN_LAG-1:0], b == trk_cfg.sync_value};
    if (b == 8'd0) begin
      if (zero_cnt != 8'hFF) zero_cnt++;
    end else begin
      zero_cnt = '0;
    end

    if (phase == PH_HEADER) begin
      hdr_bytes = {hdr_bytes[47:0], b};
      if (pos == HDR_LAST_POS) begin
        if (hdr_bytes == SIGNATURE && trk_cfg.zero_run != 8'd0) begin
          phase = PH_ZEROS;
        end else begin
          base_off = '0;
          cand_off = '0;
          phase = PH_SEARCH;
        end
      end
    end else if (phase == PH_ZEROS) begin
      if (zero_cnt >= trk_cfg.zero_run) begin
        base_off = pos;
        cand_off = pos;
        phase = PH_SEARCH;
      end
    end

    if (phase == PH_SEARCH && pos - cand_off == 32'(SPAN_LAG)) begin
      if (cand_off - base_off >= {21'd0, trk_cfg.search_span}) begin
        phase = PH_DONE;
        searches_failed++;
      end else begin
        sz = '0;
        if (sync_hist[SPAN_LAG]) begin
          if (spaced_syncs(SIZE_SHORT_I)) sz = SIZE_SHORT;
          else if (spaced_syncs(SIZE_LONG_I)) sz = SIZE_LONG;
        end
        if (sz != 8'd0) begin
          lock_vld = 1'b1;
          lock_sz  = sz;
          lock_off = cand_off;
          phase    = PH_DONE;
          if (sz == SIZE_SHORT) locks_short++;
          else locks_long++;
        end else begin
          cand_off++;
        end
      end
    end

    byte_pos = pos + 32'd1;
    r.header_seen   = (pos >= HDR_LAST_POS || phase != PH_HEADER) && hdr_bytes == SIGNATURE;
    r.search_done   = phase == PH_DONE;
    r.locked        = lock_vld;
    r.packet_size   = lock_vld ? lock_sz : 8'd0;
    r.stream_offset = lock_vld ? lock_off : 32'd0;
    return r;
  endfunction

  // Driver: predict on every accepted beat, then offer the next one
  always @(posedge clk) begin
    bit taken;
    bit idle_now;
    taken = in_valid && !in_stall;
    idle_now = (idle_mode == IDLE_SEND && $urandom_range(0, 99) < 70) ||
               (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 7);
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (taken) begin
        status_q.push_back(track_byte(in_data_byte, in_restart));
        bytes_taken <= bytes_taken + 1;
      end
      if (!in_valid || taken) begin
        if (pending_beats.size() > 0 && !idle_now &&
            !(pending_beats[0].drain && bytes_taken + int'(taken) != statuses_seen)) begin
          in_valid     <= 1'b1;
          in_data_byte <= pending_beats[0].data;
          in_restart   <= pending_beats[0].restart;
          void'(pending_beats.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each status beat against the oldest prediction
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      statuses_seen <= statuses_seen + 1;
      if (status_q.size() == 0) begin
        $error("status beat with no byte outstanding");
        err_count++;
      end else begin
        want = status_q.pop_front();
        if (out_header_seen !== want.header_seen) begin
          $error("header_seen: expected %0d, got %0d", want.header_seen, out_header_seen);
          err_count++;
        end
        if (out_search_done !== want.search_done) begin
          $error("search_done: expected %0d, got %0d", want.search_done, out_search_done);
          err_count++;
        end
        if (out_locked !== want.locked) begin
          $error("locked: expected %0d, got %0d", want.locked, out_locked);
          err_count++;
        end
        if (out_packet_size !== want.packet_size) begin
          $error("packet_size: expected %0d, got %0d", want.packet_size, out_packet_size);
          err_count++;
        end
        if (out_stream_offset !== want.stream_offset) begin
          $error("stream_offset: expected %0d, got %0d", want.stream_offset,
                 out_stream_offset);
          err_count++;
        end
      end
    end
    out_stall <= (idle_mode == IDLE_RECV && $urandom_range(0, 99) < 70) ||
                 (idle_mode == IDLE_BOTH && $urandom_range(0, 99) < 7);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic push_beat(logic [7:0] b, logic rs);
    pending_beats.push_back('{b, rs, 1'b0});
  endtask

  function automatic logic [7:0] filler_byte();
    if ($urandom_range(0, 7) == 0) return trk_cfg.sync_value;
    return 8'($urandom_range(0, 255));
  endfunction

  // Build one stream: header (random, exact or near miss), a zero run after a non-random
  // header, short lead-in, packets of psize with sync bytes, then a tail; cut > 0 truncates it.
  task automatic queue_stream(int hdr_kind, int psize, bit corrupt, int cut);
    logic [7:0] bytes[$];
    int lead;
    int bad;
    int npk;
    int tail;
    logic [7:0] sig_b;
    bad = $urandom_range(0, 6);
    for (int i = 0; i < 7; i++) begin
      sig_b = SIGNATURE[8 * (6 - i) +: 8];
      if (hdr_kind == 0) bytes.push_back(filler_byte());
      else if (hdr_kind == 2 && i == bad) bytes.push_back(sig_b ^ 8'h01);
      else bytes.push_back(sig_b);
    end
    if (hdr_kind != 0) begin
      repeat ($urandom_range(0, 10)) bytes.push_back(8'($urandom_range(1, 255)));
      // a run that breaks off short of the required length
      if (trk_cfg.zero_run > 8'd1 && $urandom_range(0, 1) == 1) begin
        repeat ($urandom_range(1, int'(trk_cfg.zero_run) - 1)) bytes.push_back(8'd0);
        bytes.push_back(8'h5A);
      end
      repeat (int'(trk_cfg.zero_run) + $urandom_range(0, 40)) bytes.push_back(8'd0);
    end
    lead = $urandom_range(0, 8);
    repeat (lead) bytes.push_back(filler_byte());
    npk = TRY_PACKETS;
    bad = corrupt ? $urandom_range(0, TRY_PACKETS - 1) : -1;
    for (int p = 0; p < npk; p++) begin
      bytes.push_back(p == bad ? trk_cfg.sync_value + 8'd1 : trk_cfg.sync_value);
      repeat (psize - 1) bytes.push_back(filler_byte());
    end
    tail = $urandom_range(0, 4);
    repeat (tail) bytes.push_back(filler_byte());
    if (cut > 0 && cut < bytes.size()) bytes = bytes[0:cut-1];
    foreach (bytes[i]) push_beat(bytes[i], i == 0);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_SYNC_VALUE:  trk_cfg.sync_value  = val[7:0];
      REG_ZERO_RUN:    trk_cfg.zero_run    = val[7:0];
      REG_SEARCH_SPAN: trk_cfg.search_span = val;
      default: ;
    endcase
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Sampled at the falling edge so the driver's queue pops have settled
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_beats.size() != 0 || in_valid || bytes_taken != statuses_seen);
    repeat (4) @(posedge clk);
  endtask

  function automatic int pick_size();
    case ($urandom_range(0, 3))
      0: return SIZE_SHORT_I;
      1, 2: return SIZE_LONG_I;
      default: return 196;  // neither size
    endcase
  endfunction

  task automatic run_phase(idle_mode_t mode, bit full_stream, bit do_write, logic [7:0] sv,
                           logic [7:0] zr, logic [10:0] sp);
    if (do_write) begin
      write_reg(REG_SYNC_VALUE, {3'd0, sv});
      write_reg(REG_ZERO_RUN, {3'd0, zr});
      write_reg(REG_SEARCH_SPAN, sp);
    end
    @(negedge clk);
    idle_mode = mode;
    if (full_stream) begin
      queue_stream($urandom_range(0, 2), pick_size(), 1'b0, 0);
    end else begin
      queue_stream($urandom_range(0, 2), pick_size(), $urandom_range(0, 3) == 0,
                   $urandom_range(20, 40));
    end
    // noise with stray restarts
    repeat (8) push_beat(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
    pending_beats[$urandom_range(0, pending_beats.size() - 1)].drain = 1'b1;
    wait_idle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Stream start without restart, byte extremes, a clean header and zero run, then a restart into a cut header
    push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(SYNC_VALUE_RST, 1'b0);
    for (int i = 0; i < 7; i++) push_beat(SIGNATURE[8 * (6 - i) +: 8], i == 0);
    repeat (10) push_beat(8'h00, 1'b0);
    push_beat(8'hFF, 1'b0);
    push_beat(8'h00, 1'b1);
    push_beat(SIGNATURE[47:40], 1'b0);
    push_beat(SIGNATURE[39:32], 1'b0);
    wait_idle();

    run_phase(IDLE_NONE, 1'b1, 1'b0, 8'd0, 8'd0, 11'd0);
    run_phase(IDLE_SEND, 1'b0, 1'b1, 8'd0, 8'd0, 11'd1024);
    run_phase(IDLE_RECV, 1'b0, 1'b1, 8'd255, 8'd255, 11'd0);
    run_phase(IDLE_BOTH, 1'b0, 1'b1, SYNC_VALUE_RST, 8'd1, 11'd1);
    run_phase(IDLE_NONE, 1'b0, 1'b1, 8'($urandom_range(0, 255)), 8'($urandom_range(1, 40)),
              11'($urandom_range(1, 300)));
    run_phase(IDLE_RECV, 1'b0, 1'b1, SYNC_VALUE_RST, ZERO_RUN_RST, 11'd1023);

    repeat (8) @(posedge clk);
    $display("Covered %0d stream bytes under six register settings, %0d statuses checked",
             bytes_taken, statuses_seen);
    $display("Searches ended: %0d locked at 188, %0d locked at 204, %0d failed",
             locks_short, locks_long, searches_failed);
    if (err_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
